FILE: rtl/core/rst_pkg.sv
// Package with shared types and constants of the retransmit slot tracker.
`default_nettype none
package rst_pkg;
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned SlotW = 4;

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActAck = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;
  localparam logic [1:0] ActNone = 2'd3;

  localparam logic [2:0] KindSent = 3'd0;
  localparam logic [2:0] KindEvict = 3'd1;
  localparam logic [2:0] KindAck = 3'd2;
  localparam logic [2:0] KindRetx = 3'd3;
  localparam logic [2:0] KindDrop = 3'd4;

  localparam logic [1:0] RegMaxRetries = 2'd0;
  localparam logic [1:0] RegInitTimeout = 2'd1;
  localparam logic [1:0] RegSeqSeed = 2'd2;

  localparam logic [7:0] MaxRetriesReset = 8'd3;
  localparam logic [31:0] InitTimeoutReset = 32'd100;

  // One slot entry as held in the table memory.
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [31:0] seq;
    logic [31:0] tx_time;
    logic [31:0] start_time;
    logic [7:0]  budget;
    logic [7:0]  retries_done;
    logic [31:0] timeout;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Timeout times 3/2, saturating at the largest 32 bit value.
  function automatic logic [31:0] grow_timeout(input logic [31:0] t);
    logic [33:0] p;
    logic [32:0] h;
    begin
      p = {2'b00, t} + {1'b0, t, 1'b0};
      h = p[33:1];
      grow_timeout = h[32] ? 32'hFFFF_FFFF : h[31:0];
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/retransmit_slot_tracker_top.sv
// Top level of the retransmit slot tracker: sequencer around the slot table RAM.
// Every send, ack or tick reads all SLOTS entries, one per cycle while a tick's scan is not stalled.
// A send passes from the scan through a write state to an emit state that issues its result;
// an ack does the same but issues a result only on a match; a tick flushes its last result.
// A result that waits on a full output register holds the item back. Reset clears the
// valid bits and counters and loads configuration defaults at once; no clearing pass.
`default_nettype none
module retransmit_slot_tracker_top #(
  parameter int unsigned SLOTS = rst_pkg::SlotsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] dest_id_i,
  input  wire logic [31:0] next_hop_i,
  input  wire logic [31:0] ack_seqno_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [3:0]       slot_o,
  output logic [31:0]      dest_id_out_o,
  output logic [31:0]      next_hop_out_o,
  output logic [31:0]      seqno_o,
  output logic [7:0]       resend_count_o,
  output logic [31:0]      latency_ms_o,
  output logic [31:0]      peak_latency_ms_o,
  output logic [31:0]      retransmit_total_o,
  output logic [31:0]      drop_total_o,
  output logic             last_o
);
  import rst_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned RamD = 1 << IdxW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  logic [2:0] st_q;
  logic [7:0] max_retries_q;
  logic [31:0] init_to_q, next_seq_q, peak_q, retx_q, drop_q;
  logic [SLOTS-1:0] valid_q;
  logic [1:0] act_q;
  logic [31:0] dest_q, hop_q, ack_q, now_q;
  logic [CntW-1:0] rd_cnt_q;   // next address to read
  logic            rv_q;       // read data valid for address rd_idx_q
  logic [IdxW-1:0] rd_idx_q;
  logic            found_q;    // send: free slot found / ack: match found
  logic [IdxW-1:0] pick_q;
  logic [31:0]     min_q;
  logic [31:0]     lat_q;
  entry_t          ent_q;      // held entry for the result
  logic            pend_q;     // tick result waiting to be emitted
  logic [2:0]      pkind_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata, new_ent, retx_ent;

  rst_ram #(.Width(EntryW), .Depth(RamD)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // output register
  logic ov_q;
  logic [2:0] okind_q;
  logic [IdxW-1:0] oslot_q;
  entry_t oent_q;
  logic [31:0] olat_q, opeak_q, oretx_q, odrop_q;
  logic olast_q;
  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  assign in_ready_o = (st_q == StIdle);

  logic scan_done;
  assign scan_done = (rd_cnt_q == CntW'(SLOTS));

  logic [31:0] age, peak_new;
  logic expired, ok_rd, stall, tick_hit;
  logic issue_scan, issue_emit, issue_flush, issue;
  assign age = now_q - rdata.tx_time;
  assign ok_rd = rv_q && valid_q[rd_idx_q];
  assign expired = ok_rd && (age >= rdata.timeout);
  // A tick holds its scan while the previous result cannot leave for the next one.
  assign stall = (st_q == StScan) && (act_q == ActTick) && pend_q && expired && !out_free;
  assign tick_hit = (st_q == StScan) && !stall && (act_q == ActTick) && expired;
  assign raddr = stall ? rd_idx_q : rd_cnt_q[IdxW-1:0];
  assign peak_new = (lat_q > peak_q) ? lat_q : peak_q;

  assign issue_scan = tick_hit && pend_q;
  assign issue_emit = (st_q == StEmit) && ((act_q == ActSend) || found_q) && out_free;
  assign issue_flush = (st_q == StFlush) && pend_q && out_free;
  assign issue = issue_scan || issue_emit || issue_flush;

  always_comb begin
    new_ent.dest = dest_q;
    new_ent.hop = hop_q;
    new_ent.seq = next_seq_q;
    new_ent.tx_time = now_q;
    new_ent.start_time = now_q;
    new_ent.budget = max_retries_q;
    new_ent.retries_done = 8'd0;
    new_ent.timeout = init_to_q;
  end

  always_comb begin
    retx_ent = rdata;
    retx_ent.budget = rdata.budget - 8'd1;
    retx_ent.retries_done = rdata.retries_done + 8'd1;
    retx_ent.tx_time = now_q;
    retx_ent.timeout = grow_timeout(rdata.timeout);
  end

  assign we = (tick_hit && (rdata.budget != 8'd0)) ||
              ((st_q == StWrite) && (act_q == ActSend));
  assign waddr = (st_q == StScan) ? rd_idx_q : pick_q;
  assign wdata = (st_q == StScan) ? retx_ent : new_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      max_retries_q <= MaxRetriesReset;
      init_to_q <= InitTimeoutReset;
      next_seq_q <= '0;
      peak_q <= '0;
      retx_q <= '0;
      drop_q <= '0;
      valid_q <= '0;
      rv_q <= 1'b0;
      rd_cnt_q <= '0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      ov_q <= issue || (ov_q && !out_ready_i);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegMaxRetries: max_retries_q <= cfg_data_i[7:0];
          RegInitTimeout: init_to_q <= cfg_data_i;
          RegSeqSeed: next_seq_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          act_q <= action_i;
          dest_q <= dest_id_i;
          hop_q <= next_hop_i;
          ack_q <= ack_seqno_i;
          now_q <= now_ms_i;
          rd_cnt_q <= '0;
          rv_q <= 1'b0;
          found_q <= 1'b0;
          pend_q <= 1'b0;
          pick_q <= '0;
          if (action_i != ActNone) st_q <= StScan;
        end
        StScan: if (!stall) begin
          if (!scan_done) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          rv_q <= !scan_done;
          rd_idx_q <= rd_cnt_q[IdxW-1:0];
          if (rv_q) begin
            priority case (act_q)
              ActSend: begin
                if (!found_q) begin
                  if (!valid_q[rd_idx_q]) begin
                    found_q <= 1'b1;
                    pick_q <= rd_idx_q;
                  end else if (rd_idx_q == '0 || rdata.start_time < min_q) begin
                    pick_q <= rd_idx_q;
                    min_q <= rdata.start_time;
                  end
                end
              end
              ActAck: if (!found_q && ok_rd && rdata.seq == ack_q) begin
                found_q <= 1'b1;
                pick_q <= rd_idx_q;
                ent_q <= rdata;
                lat_q <= age;
              end
              default: if (expired) begin
                pend_q <= 1'b1;
                pick_q <= rd_idx_q;
                if (rdata.budget != 8'd0) begin
                  ent_q <= retx_ent;
                  retx_q <= retx_q + 32'd1;
                  pkind_q <= KindRetx;
                end else begin
                  ent_q <= rdata;
                  valid_q[rd_idx_q] <= 1'b0;
                  drop_q <= drop_q + 32'd1;
                  pkind_q <= KindDrop;
                end
              end
            endcase
          end
          if (!rv_q && scan_done) begin
            st_q <= (act_q == ActTick) ? StFlush : StWrite;
          end
        end
        StWrite: begin
          if (act_q == ActSend) begin
            valid_q[pick_q] <= 1'b1;
            next_seq_q <= next_seq_q + 32'd1;
            ent_q <= new_ent;
          end
          st_q <= StEmit;
        end
        StEmit: begin
          // Wait for the RAM write to land, then issue the single result if there is one.
          if (act_q == ActSend || found_q) begin
            if (out_free) begin
              if (act_q != ActSend) begin
                peak_q <= peak_new;
                valid_q[pick_q] <= 1'b0;
              end
              st_q <= StIdle;
            end
          end else begin
            st_q <= StIdle;
          end
        end
        StFlush: begin
          if (!pend_q) begin
            st_q <= StIdle;
          end else if (out_free) begin
            pend_q <= 1'b0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Payload of the output register, captured as a result is issued.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      oslot_q <= pick_q;
      oent_q <= ent_q;
      oretx_q <= retx_q;
      odrop_q <= drop_q;
      olast_q <= !issue_scan;
      if (issue_emit) begin
        okind_q <= (act_q == ActSend) ? (found_q ? KindSent : KindEvict) : KindAck;
        olat_q <= (act_q == ActSend) ? 32'd0 : lat_q;
        opeak_q <= (act_q == ActSend) ? peak_q : peak_new;
      end else begin
        okind_q <= pkind_q;
        olat_q <= 32'd0;
        opeak_q <= peak_q;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = okind_q;
  assign slot_o = 4'(oslot_q);
  assign dest_id_out_o = oent_q.dest;
  assign next_hop_out_o = oent_q.hop;
  assign seqno_o = oent_q.seq;
  assign resend_count_o = oent_q.retries_done;
  assign latency_ms_o = olat_q;
  assign peak_latency_ms_o = opeak_q;
  assign retransmit_total_o = oretx_q;
  assign drop_total_o = odrop_q;
  assign last_o = olast_q;
endmodule
`default_nettype wire
